[hdl/bcsc_pkg.sv]
// Shared types, codes and BCD helpers for the clock alarm-setting controller.
package bcsc_pkg;

  // Request codes carried by req_type.
  typedef enum logic [2:0] {
    REQ_MODE   = 3'd0,
    REQ_SELECT = 3'd1,
    REQ_ADD    = 3'd2,
    REQ_OK     = 3'd3,
    REQ_TICK   = 3'd4
  } req_t;

  // Operating modes.
  typedef enum logic [1:0] {
    MODE_RUN       = 2'd0,
    MODE_SET_TIME  = 2'd1,
    MODE_SET_ALARM = 2'd2
  } mode_t;

  // Byte slots of the packed time word.
  localparam logic [2:0] SLOT_SEC   = 3'd0;
  localparam logic [2:0] SLOT_MIN   = 3'd1;
  localparam logic [2:0] SLOT_HOUR  = 3'd2;
  localparam logic [2:0] SLOT_DAY   = 3'd3;
  localparam logic [2:0] SLOT_MONTH = 3'd4;
  localparam logic [2:0] SLOT_WEEK  = 3'd5;
  localparam logic [2:0] SLOT_YEAR  = 3'd6;
  localparam int unsigned NUM_SLOTS = 7;

  // Alarm-mode cursor positions.
  localparam logic [2:0] ACUR_MINUTE = 3'd0;
  localparam logic [2:0] ACUR_HOUR   = 3'd1;
  localparam logic [2:0] ACUR_ENABLE = 3'd2;
  localparam logic [2:0] ACUR_RESET  = 3'd3;

  // Last cursor position before the select key wraps.
  localparam logic [2:0] CURSOR_LAST = 3'd6;

  // Wrap threshold and restart value per byte slot (sec, min, hour, day, month, week, year).
  localparam logic [6:0][7:0] SLOT_LIMIT = {8'h99, 8'h08, 8'h13, 8'h32, 8'h24, 8'h60, 8'h60};
  localparam logic [6:0][7:0] SLOT_START = {8'h00, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00, 8'h00};

  localparam logic [7:0] MIN_LIMIT  = 8'h60;
  localparam logic [7:0] HOUR_LIMIT = 8'h24;

  // Architectural state of the controller.
  typedef struct packed {
    mode_t            mode;
    logic [2:0]       cursor;
    logic [6:0][7:0]  fields;
    logic [7:0]       alarm_min;
    logic [7:0]       alarm_hour;
    logic             alarm_on;
    logic             set_ok;
    logic             add_pending;
    logic             first_tick;
  } state_t;

  localparam state_t STATE_RESET = '{
    mode:        MODE_RUN,
    cursor:      3'd0,
    fields:      '0,
    alarm_min:   8'h00,
    alarm_hour:  8'h00,
    alarm_on:    1'b0,
    set_ok:      1'b0,
    add_pending: 1'b0,
    first_tick:  1'b1
  };

  // Per-item flags that are not part of the state.
  typedef struct packed {
    logic ring;
    logic save;
    logic beep;
  } flags_t;

  // BCD increment with a wrap to a restart value at a limit.
  function automatic logic [7:0] bcd_step(input logic [7:0] v, input logic [7:0] limit,
                                          input logic [7:0] restart);
    logic [7:0] r;
    r = v + 8'd1;
    if (r[3:0] > 4'd9) r = r + 8'd6;
    if (r >= limit) r = restart;
    return r;
  endfunction

  // Time-mode cursor order is sec, min, hour, week, day, month, year.
  function automatic logic [2:0] cursor_slot(input logic [2:0] cur);
    logic [2:0] s;
    case (cur)
      3'd0:    s = SLOT_SEC;
      3'd1:    s = SLOT_MIN;
      3'd2:    s = SLOT_HOUR;
      3'd3:    s = SLOT_WEEK;
      3'd4:    s = SLOT_DAY;
      3'd5:    s = SLOT_MONTH;
      3'd6:    s = SLOT_YEAR;
      default: s = 3'd7;
    endcase
    return s;
  endfunction

endpackage

[hdl/bcd_clock_alarm_set_controller.sv]
// Top level of the BCD clock alarm-setting controller.
// An accepted item waits in the input register until the result register can take it, and the result is registered.
// Throughput: one item per cycle while out_ready stays high; the state update is a single pass of logic in bcsc_core.
// The input stage frees whenever the result register is empty or being taken.
// Reset (rst, synchronous) empties both stages and returns mode, cursor, time, alarm and flags
// to their initial values, with the first-tick alarm capture armed.
module bcd_clock_alarm_set_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [55:0] rtc_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  mode_now,
  output logic [2:0]  field_cursor,
  output logic [55:0] time_bcd,
  output logic [7:0]  alarm_minute,
  output logic [7:0]  alarm_hour,
  output logic        alarm_enabled,
  output logic        alarm_ring,
  output logic        save_time,
  output logic        beep
);
  import bcsc_pkg::*;

  logic        s1_valid;
  logic [2:0]  s1_req;
  logic [55:0] s1_rtc;
  logic        advance;
  state_t      state;
  state_t      state_next;
  flags_t      flags;

  // An item moves on when the result register can take it.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_req <= req_type;
      s1_rtc <= rtc_time;
    end
  end

  bcsc_core u_core (
    .cur   (state),
    .req   (req_t'(s1_req)),
    .rtc   (s1_rtc),
    .nxt   (state_next),
    .flags (flags)
  );

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      mode_now      <= state_next.mode;
      field_cursor  <= state_next.cursor;
      time_bcd      <= state_next.fields;
      alarm_minute  <= state_next.alarm_min;
      alarm_hour    <= state_next.alarm_hour;
      alarm_enabled <= state_next.alarm_on;
      alarm_ring    <= flags.ring;
      save_time     <= flags.save;
      beep          <= flags.beep;
    end
  end

endmodule

[hdl/bcsc_core.sv]
// Next-state and result logic for one item of the clock alarm-setting controller.
module bcsc_core (
  input  bcsc_pkg::state_t cur,
  input  bcsc_pkg::req_t   req,
  input  logic [55:0]      rtc,
  output bcsc_pkg::state_t nxt,
  output bcsc_pkg::flags_t flags
);
  import bcsc_pkg::*;

  state_t     ev;
  logic [2:0] slot;
  logic       ring;
  logic       save;
  logic       beep;

  // Apply the event itself.
  always_comb begin
    ev = cur;
    save = 1'b0;
    beep = 1'b0;
    case (req)
      REQ_MODE: begin
        case (cur.mode)
          MODE_RUN:      ev.mode = MODE_SET_TIME;
          MODE_SET_TIME: ev.mode = MODE_SET_ALARM;
          default:       ev.mode = MODE_SET_TIME;
        endcase
        ev.set_ok = 1'b0;
        ev.cursor = 3'd0;
        beep      = 1'b1;
      end
      REQ_SELECT: begin
        ev.cursor = (cur.cursor >= CURSOR_LAST) ? 3'd0 : cur.cursor + 3'd1;
        beep      = 1'b1;
      end
      REQ_ADD: begin
        ev.add_pending = 1'b1;
        beep           = 1'b1;
      end
      REQ_OK: begin
        ev.set_ok = 1'b1;
        ev.cursor = 3'd0;
        ev.mode   = MODE_RUN;
        save      = 1'b1;
        beep      = 1'b1;
      end
      REQ_TICK: begin
        // The first tick latches the held hour and minute as the alarm.
        if (cur.first_tick) begin
          ev.first_tick = 1'b0;
          ev.alarm_min  = cur.fields[SLOT_MIN];
          ev.alarm_hour = cur.fields[SLOT_HOUR];
        end
        if (cur.mode == MODE_RUN) ev.fields = rtc;
      end
      default: ;
    endcase
  end

  assign slot = cursor_slot(ev.cursor);

  // Apply a pending add in the setting modes; in run mode it stays pending.
  always_comb begin
    nxt = ev;
    if (ev.add_pending) begin
      case (ev.mode)
        MODE_SET_TIME: begin
          nxt.add_pending = 1'b0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot == i[2:0])
              nxt.fields[i] = bcd_step(ev.fields[i], SLOT_LIMIT[i], SLOT_START[i]);
          end
        end
        MODE_SET_ALARM: begin
          nxt.add_pending = 1'b0;
          case (ev.cursor)
            ACUR_MINUTE: nxt.alarm_min  = bcd_step(ev.alarm_min, MIN_LIMIT, 8'h00);
            ACUR_HOUR:   nxt.alarm_hour = bcd_step(ev.alarm_hour, HOUR_LIMIT, 8'h00);
            ACUR_ENABLE: nxt.alarm_on   = ~ev.alarm_on;
            ACUR_RESET:  nxt.cursor     = 3'd0;
            default:     ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // The alarm rings while enabled, set ok, and the held time matches.
  assign ring = nxt.alarm_on && nxt.set_ok &&
                (nxt.alarm_hour == nxt.fields[SLOT_HOUR]) &&
                (nxt.alarm_min == nxt.fields[SLOT_MIN]);

  assign flags = '{ring: ring, save: save, beep: beep};

endmodule
